### rtl/orrb_pkg.sv
// ----------------------------------------------------------------------------
// orrb_pkg
// Shared types and constants for the overwriting record ring buffer:
// command codes, register indexes, field widths and the control/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package orrb_pkg;

  // fixed field widths of the ports
  localparam int FUNC_BITS      = 2;
  localparam int LEN_BITS       = 16;
  localparam int DATA_BITS      = 8;
  localparam int COUNT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 4;
  localparam int CAP_LOG2_BITS  = 4;
  localparam int HDR_BITS       = 2;

  // command codes
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_PEEK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY_LOG2   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_ELEMENTS = 2'd1;

  // register reset values
  localparam logic [CAP_LOG2_BITS-1:0] CAPACITY_LOG2_RESET   = 4'd10;
  localparam logic [HDR_BITS-1:0]      HEADER_ELEMENTS_RESET = 2'd0;

  // controller to datapath commands
  typedef struct packed {
    logic latch;         // capture the accepted item
    logic cfg_write;     // register write, empties the ring
    logic setup_write;   // clamp length, work out overflow
    logic elem_step;     // store one write element, report on completion
    logic fetch_init;    // clear header accumulator and index
    logic fetch_read;    // read one header element
    logic fetch_acc;     // shift header element into accumulator
    logic drop_step;     // drop the oldest record
    logic hdr_write;     // write one length header element
    logic write_finish;  // commit write pointer and counters
    logic read_flat;     // set up a flat read or an empty read
    logic read_record;   // set up a record read
    logic emit;          // read out one element as a result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 first;
    logic                 wrem_zero;
    logic                 hdr_zero;
    logic                 used_zero;
    logic                 over_zero;
    logic                 fetch_last;
    logic                 flat_empty;
    logic                 rec_empty;
    logic                 rleft_one;
  } status_t;

endpackage

### rtl/overwriting_record_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// overwriting_record_ring_buffer_top
// Power-of-two ring FIFO that overwrites its oldest data, in flat mode or
// with length-prefixed records.
//
// Usage: an item (func, first, length, data) is taken at a clock edge with
// start high and busy low. Writes come one element per item, the first item
// carrying the total length; the item that completes a write gives one
// result with count set. Pop and peek give a run of up to MAX_READ results,
// one per cycle, the final one marked by last and carrying the count; an
// empty read gives a single data-less result.
// Each result shows on the result ports for one cycle with result_strobe;
// the receiver cannot stall, and nothing waits on it.
// A first write element takes longer in record mode, and longer again for each
// dropped record; a read run issues its element reads back to back, with
// each result in the cycle after its read. The single read port of the ring
// store paces these steps.
// Registers are written on cfg_valid with cfg_ready (high while idle); a write
// to either register empties the ring, and writes to other indexes are ignored.
// Reset empties the ring and restores capacity_log2 = 10 and flat mode; the store itself is not cleared.
// ----------------------------------------------------------------------------
module overwriting_record_ring_buffer_top #(
  parameter int DEPTH     = 1024,
  parameter int ELEM_BITS = 8,
  parameter int MAX_READ  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [orrb_pkg::FUNC_BITS-1:0]      func,
  input  logic                                first,
  input  logic [orrb_pkg::LEN_BITS-1:0]       length,
  input  logic [orrb_pkg::DATA_BITS-1:0]      data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [orrb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [orrb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                result_strobe,
  output logic [orrb_pkg::DATA_BITS-1:0]      element,
  output logic                                has_element,
  output logic [orrb_pkg::COUNT_BITS-1:0]     count,
  output logic                                last
);
  import orrb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  orrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .status    (status),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // ring store and arithmetic
  orrb_datapath #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS),
    .MAX_READ  (MAX_READ)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .first         (first),
    .length        (length),
    .data          (data),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .element       (element),
    .has_element   (has_element),
    .count         (count),
    .last          (last)
  );

endmodule

### rtl/orrb_datapath.sv
// ----------------------------------------------------------------------------
// orrb_datapath
// Ring store, pointers, write bookkeeping, header fetch and read-out
// registers of the overwriting record ring buffer. Acts on commands from
// the controller and reports status back.
// ----------------------------------------------------------------------------
module orrb_datapath #(
  parameter int DEPTH     = 1024,
  parameter int ELEM_BITS = 8,
  parameter int MAX_READ  = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  orrb_pkg::cmd_t                         cmd,
  output orrb_pkg::status_t                      status,
  input  logic [orrb_pkg::FUNC_BITS-1:0]         func,
  input  logic                                   first,
  input  logic [orrb_pkg::LEN_BITS-1:0]          length,
  input  logic [orrb_pkg::DATA_BITS-1:0]         data,
  input  logic [orrb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [orrb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic                                   result_strobe,
  output logic [orrb_pkg::DATA_BITS-1:0]         element,
  output logic                                   has_element,
  output logic [orrb_pkg::COUNT_BITS-1:0]        count,
  output logic                                   last
);
  import orrb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int NW = $clog2(MAX_READ + 1);
  localparam int SW = ((PW > LEN_BITS) ? PW : LEN_BITS) + 2;

  // ring store
  logic [ELEM_BITS-1:0] mem [DEPTH];
  logic [ELEM_BITS-1:0] rdata;

  // configuration and ring state
  logic [CAP_LOG2_BITS-1:0] cap_log2;
  logic [HDR_BITS-1:0]      hdr_cfg;
  logic [PW-1:0]            wp;
  logic [PW-1:0]            rp;
  logic [LEN_BITS-1:0]      wrem;
  logic [LEN_BITS-1:0]      wacc;

  // captured item and work registers
  logic [FUNC_BITS-1:0] func_q;
  logic                 first_q;
  logic [LEN_BITS-1:0]  length_q;
  logic [DATA_BITS-1:0] data_q;
  logic [LEN_BITS-1:0]  len_q;
  logic [PW-1:0]        over_q;
  logic [LEN_BITS-1:0]  hv;
  logic                 hidx;
  logic [PW-1:0]        raddr;
  logic [NW-1:0]        rleft;
  logic [NW-1:0]        rn;

  // result registers
  logic                  out_strobe;
  logic                  out_has;
  logic                  out_last;
  logic [COUNT_BITS-1:0] out_count;

  // derived values
  logic [CAP_LOG2_BITS-1:0] lg_eff;
  logic [PW-1:0]            cap;
  logic [PW-1:0]            capm;
  logic [HDR_BITS-1:0]      hdr;
  logic [PW-1:0]            used;
  logic [SW-1:0] cap_s, used_s, hdr_s, hv_s, length_s;
  logic [SW-1:0] lim_s, len_s, total_s, over_s;
  logic [SW-1:0] hsum_s, step_s, want_s, nflat_s, body_s, nrec_s, adv_s;
  logic [DATA_BITS-1:0] hdr_byte;

  // store port selection
  logic                 mem_we;
  logic                 mem_re;
  logic [PW-1:0]        wptr;
  logic [PW-1:0]        rptr;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr_m;
  logic [ELEM_BITS-1:0] wdata;

  // capacity, header count and fill level
  always_comb begin
    lg_eff = (cap_log2 == '0) ? CAP_LOG2_BITS'(1) : cap_log2;
    cap    = (int'(lg_eff) >= AW) ? PW'(DEPTH) : (PW'(1) << lg_eff);
    capm   = cap - PW'(1);
    hdr    = (hdr_cfg == 2'd3) ? 2'd2 : hdr_cfg;
    used   = wp - rp;
  end

  // write setup, drop step and read setup arithmetic
  always_comb begin
    cap_s    = SW'(cap);
    used_s   = SW'(used);
    hdr_s    = SW'(hdr);
    hv_s     = SW'(hv);
    length_s = SW'(length_q);

    lim_s = cap_s - hdr_s;
    if (hdr == 2'd1 && lim_s > SW'(255)) begin
      lim_s = SW'(255);
    end
    len_s   = (length_s < lim_s) ? length_s : lim_s;
    total_s = used_s + hdr_s + len_s;
    over_s  = (total_s > cap_s) ? total_s - cap_s : '0;

    hsum_s = hdr_s + hv_s;
    step_s = (hsum_s > used_s) ? used_s : hsum_s;

    want_s  = (length_s > SW'(MAX_READ)) ? SW'(MAX_READ) : length_s;
    nflat_s = (want_s < used_s) ? want_s : used_s;
    body_s  = (used_s > hdr_s) ? used_s - hdr_s : '0;
    nrec_s  = want_s;
    if (hv_s < nrec_s) begin
      nrec_s = hv_s;
    end
    if (body_s < nrec_s) begin
      nrec_s = body_s;
    end
    adv_s = (hsum_s > used_s) ? used_s : hsum_s;

    // most significant byte goes first
    hdr_byte = (hdr == 2'd2 && !hidx) ? len_q[15:8] : len_q[7:0];
  end

  // store port muxing
  always_comb begin
    mem_we  = (cmd.elem_step && wrem != '0) || cmd.hdr_write;
    wptr    = cmd.hdr_write ? wp + PW'(hidx) : wp - PW'(wrem);
    wdata   = cmd.hdr_write ? ELEM_BITS'(hdr_byte) : ELEM_BITS'(data_q);
    mem_re  = cmd.fetch_read || cmd.emit;
    rptr    = cmd.emit ? raddr : rp + PW'(hidx);
    waddr   = wptr[AW-1:0] & capm[AW-1:0];
    raddr_m = rptr[AW-1:0] & capm[AW-1:0];
  end

  // ring store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr_m];
    end
  end

  // configuration, pointers, write counters and results
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2   <= CAPACITY_LOG2_RESET;
      hdr_cfg    <= HEADER_ELEMENTS_RESET;
      wp         <= '0;
      rp         <= '0;
      wrem       <= '0;
      wacc       <= '0;
      out_strobe <= 1'b0;
      out_has    <= 1'b0;
      out_last   <= 1'b0;
      out_count  <= '0;
    end else begin
      out_strobe <= 1'b0;

      // element store and completion report
      if (cmd.elem_step) begin
        if (wrem != '0) begin
          wrem <= wrem - LEN_BITS'(1);
        end
        if (wrem <= LEN_BITS'(1)) begin
          out_strobe <= 1'b1;
          out_has    <= 1'b0;
          out_last   <= 1'b1;
          out_count  <= wacc;
        end
      end

      // drop the oldest record
      if (cmd.drop_step) begin
        rp <= rp + PW'(step_s);
      end

      // commit the reserved space
      if (cmd.write_finish) begin
        wp   <= wp + PW'(hdr) + PW'(len_q);
        wrem <= len_q;
        wacc <= len_q;
        if (hdr == '0) begin
          rp <= rp + over_q;
        end
      end

      // flat read, or a read of an empty ring
      if (cmd.read_flat) begin
        if (func_q == FUNC_POP) begin
          rp <= rp + PW'(nflat_s);
        end
        if (nflat_s == '0) begin
          out_strobe <= 1'b1;
          out_has    <= 1'b0;
          out_last   <= 1'b1;
          out_count  <= '0;
        end
      end

      // record read
      if (cmd.read_record) begin
        if (func_q == FUNC_POP) begin
          rp <= rp + PW'(adv_s);
        end
        if (nrec_s == '0) begin
          out_strobe <= 1'b1;
          out_has    <= 1'b0;
          out_last   <= 1'b1;
          out_count  <= '0;
        end
      end

      // one element of a read run
      if (cmd.emit) begin
        out_strobe <= 1'b1;
        out_has    <= 1'b1;
        out_last   <= (rleft == NW'(1));
        out_count  <= (rleft == NW'(1)) ? COUNT_BITS'(rn) : '0;
      end

      // a write to either register empties the ring
      if (cmd.cfg_write) begin
        case (cfg_index)
          REG_CAPACITY_LOG2: begin
            cap_log2 <= cfg_data;
            wp       <= '0;
            rp       <= '0;
            wrem     <= '0;
            wacc     <= '0;
          end
          REG_HEADER_ELEMENTS: begin
            hdr_cfg <= cfg_data[HDR_BITS-1:0];
            wp      <= '0;
            rp      <= '0;
            wrem    <= '0;
            wacc    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // item capture and work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q   <= func;
      first_q  <= first;
      length_q <= length;
      data_q   <= data;
    end
    if (cmd.setup_write) begin
      len_q  <= len_s[LEN_BITS-1:0];
      over_q <= PW'(over_s);
    end
    if (cmd.fetch_init) begin
      hv   <= '0;
      hidx <= 1'b0;
    end
    if (cmd.fetch_acc) begin
      hv   <= {hv[7:0], rdata[7:0]};
      hidx <= hidx + 1'b1;
    end
    if (cmd.hdr_write) begin
      hidx <= hidx + 1'b1;
    end
    if (cmd.drop_step) begin
      over_q <= (step_s < SW'(over_q)) ? over_q - PW'(step_s) : '0;
    end
    if (cmd.read_flat) begin
      raddr <= rp;
      rleft <= NW'(nflat_s);
      rn    <= NW'(nflat_s);
    end
    if (cmd.read_record) begin
      raddr <= rp + PW'(hdr);
      rleft <= NW'(nrec_s);
      rn    <= NW'(nrec_s);
    end
    if (cmd.emit) begin
      raddr <= raddr + PW'(1);
      rleft <= rleft - NW'(1);
    end
  end

  // status to the controller
  always_comb begin
    status.func       = func_q;
    status.first      = first_q;
    status.wrem_zero  = (wrem == '0);
    status.hdr_zero   = (hdr == '0);
    status.used_zero  = (used == '0);
    status.over_zero  = (over_q == '0);
    status.fetch_last = (hdr == 2'd1) || hidx;
    status.flat_empty = (nflat_s == '0);
    status.rec_empty  = (nrec_s == '0);
    status.rleft_one  = (rleft == NW'(1));
  end

  // result ports
  assign result_strobe = out_strobe;
  assign element       = out_has ? rdata[DATA_BITS-1:0] : '0;
  assign has_element   = out_has;
  assign count         = out_count;
  assign last          = out_last;

  // ring never holds more than its capacity
  a_used_in_cap: assert property (@(posedge clk) disable iff (rst) used <= cap)
    else $error("ring fill exceeds capacity");

  // pending elements never exceed the accepted length
  a_wrem_le_wacc: assert property (@(posedge clk) disable iff (rst) wrem <= wacc)
    else $error("write remaining exceeds accepted length");

  // a result without data always closes its command
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && !out_has) |-> out_last)
    else $error("data-less result not marked last");

endmodule

### rtl/orrb_ctrl.sv
// ----------------------------------------------------------------------------
// orrb_ctrl
// Controller of the overwriting record ring buffer: accepts items, then
// sequences write setup, record dropping, header writes, header fetches
// and read runs through the datapath.
// ----------------------------------------------------------------------------
module orrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cfg_valid,
  input  orrb_pkg::status_t status,
  output logic              busy,
  output logic              cfg_ready,
  output orrb_pkg::cmd_t    cmd
);
  import orrb_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_DROP   = 4'd2;
  localparam logic [3:0] S_HREAD  = 4'd3;
  localparam logic [3:0] S_HACC   = 4'd4;
  localparam logic [3:0] S_DSTEP  = 4'd5;
  localparam logic [3:0] S_WHDR   = 4'd6;
  localparam logic [3:0] S_WFIN   = 4'd7;
  localparam logic [3:0] S_WDATA  = 4'd8;
  localparam logic [3:0] S_RSETUP = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.cfg_write = cfg_valid;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.func)
          FUNC_WRITE: begin
            if (status.first) begin
              cmd.setup_write = 1'b1;
              state_next      = status.hdr_zero ? S_WFIN : S_DROP;
            end else begin
              cmd.elem_step = !status.wrem_zero;
              state_next    = S_IDLE;
            end
          end
          FUNC_POP, FUNC_PEEK: begin
            if (status.hdr_zero || status.used_zero) begin
              cmd.read_flat = 1'b1;
              state_next    = status.flat_empty ? S_IDLE : S_EMIT;
            end else begin
              cmd.fetch_init = 1'b1;
              state_next     = S_HREAD;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DROP: begin
        cmd.fetch_init = 1'b1;
        if (status.over_zero || status.used_zero) begin
          state_next = S_WHDR;
        end else begin
          state_next = S_HREAD;
        end
      end
      S_HREAD: begin
        cmd.fetch_read = 1'b1;
        state_next     = S_HACC;
      end
      S_HACC: begin
        cmd.fetch_acc = 1'b1;
        if (!status.fetch_last) begin
          state_next = S_HREAD;
        end else if (status.func == FUNC_WRITE) begin
          state_next = S_DSTEP;
        end else begin
          state_next = S_RSETUP;
        end
      end
      S_DSTEP: begin
        cmd.drop_step = 1'b1;
        state_next    = S_DROP;
      end
      S_WHDR: begin
        cmd.hdr_write = 1'b1;
        if (status.fetch_last) begin
          state_next = S_WFIN;
        end
      end
      S_WFIN: begin
        cmd.write_finish = 1'b1;
        state_next       = S_WDATA;
      end
      S_WDATA: begin
        cmd.elem_step = 1'b1;
        state_next    = S_IDLE;
      end
      S_RSETUP: begin
        cmd.read_record = 1'b1;
        state_next      = status.rec_empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.rleft_one) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath commands never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.setup_write, cmd.elem_step, cmd.fetch_init, cmd.fetch_read,
              cmd.fetch_acc, cmd.drop_step, cmd.hdr_write, cmd.write_finish,
              cmd.read_flat, cmd.read_record, cmd.emit}))
    else $error("overlapping datapath commands");

  // header work only in record mode
  a_hdr_mode: assert property (@(posedge clk) disable iff (rst)
    (state == S_HREAD || state == S_WHDR) |-> !status.hdr_zero)
    else $error("header sequence in flat mode");

  // work begins only on an accepted item
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted item");

endmodule

### tb/overwriting_record_ring_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// overwriting_record_ring_buffer_top_tb
// Self-checking bench for the overwriting record ring buffer. A short table
// of directed commands runs first: register extremes, empty reads, clamped
// lengths, abandoned writes and ignored items. Random phases with new
// settings follow. Every result is compared against a result typed in the
// table or an in-bench model of the ring kept in step with accepted items.
// ----------------------------------------------------------------------------
module overwriting_record_ring_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import orrb_pkg::*;

  localparam int RING_DEPTH    = 1024;
  localparam int READ_CAP      = 64;
  localparam int unsigned PTR_WRAP = 2 * RING_DEPTH - 1;
  localparam int RANDOM_ITEMS  = 180;
  localparam int QUIET_CYCLES  = 16;
  localparam int TAIL_CYCLES   = 100;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // capacity used for the initial fill; random phases stay at or below it
  localparam logic [CFG_DATA_BITS-1:0] FILL_CAP_LOG2 = 4'd7;

  // unused command code, ignored by the block
  localparam logic [FUNC_BITS-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 first;
    logic [LEN_BITS-1:0]  length;
    logic [DATA_BITS-1:0] data;
  } ring_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  element;
    logic                  has_element;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
  } result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} check_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_INDEX_BITS-1:0] reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_val;
    ring_item_t                it;
    check_e                    chk;
    result_t                   res;
  } row_t;

  localparam ring_item_t NO_ITEM   = '0;
  localparam result_t    RUN_EMPTY = '{element: 8'h00, has_element: 1'b0,
                                       count: 16'd0, last: 1'b1};
  localparam result_t    WROTE_1   = '{element: 8'h00, has_element: 1'b0,
                                       count: 16'd1, last: 1'b1};
  localparam result_t    WROTE_2   = '{element: 8'h00, has_element: 1'b0,
                                       count: 16'd2, last: 1'b1};

  // block ports
  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [FUNC_BITS-1:0]      func = '0;
  logic                      first = 1'b0;
  logic [LEN_BITS-1:0]       length = '0;
  logic [DATA_BITS-1:0]      data = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      result_strobe;
  logic [DATA_BITS-1:0]      element;
  logic                      has_element;
  logic [COUNT_BITS-1:0]     count;
  logic                      last;

  overwriting_record_ring_buffer_top #(
    .DEPTH    (RING_DEPTH),
    .ELEM_BITS(8),
    .MAX_READ (READ_CAP)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .first        (first),
    .length       (length),
    .data         (data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_strobe(result_strobe),
    .element      (element),
    .has_element  (has_element),
    .count        (count),
    .last         (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ring mirror: store, pointers, pending write and registers
  logic [DATA_BITS-1:0]     ring_mem [0:RING_DEPTH-1];
  int unsigned              wr_ptr;
  int unsigned              rd_ptr;
  int unsigned              wr_left;
  int unsigned              wr_len;
  logic [CAP_LOG2_BITS-1:0] cap_log2_reg = CAPACITY_LOG2_RESET;
  logic [HDR_BITS-1:0]      hdr_reg = HEADER_ELEMENTS_RESET;

  result_t ring_step_out [$];
  result_t awaited_q [$];
  int      mismatches  = 0;
  int      items_done  = 0;
  int      burst_left  = 0;
  int      cycle_count = 0;

  function automatic void clear_ring();
    wr_ptr  = 0;
    rd_ptr  = 0;
    wr_left = 0;
    wr_len  = 0;
  endfunction

  function automatic int unsigned ring_cap();
    int unsigned lg = cap_log2_reg;
    int unsigned c;
    if (lg < 1) lg = 1;
    c = 1 << lg;
    if (c > RING_DEPTH) c = RING_DEPTH;
    return c;
  endfunction

  function automatic int unsigned hdr_count();
    return (hdr_reg == 2'd3) ? 2 : int'(hdr_reg);
  endfunction

  function automatic logic [DATA_BITS-1:0] mem_get(int unsigned ptr);
    return ring_mem[ptr & (ring_cap() - 1)];
  endfunction

  function automatic void mem_put(int unsigned ptr, logic [DATA_BITS-1:0] v);
    ring_mem[ptr & (ring_cap() - 1)] = v;
  endfunction

  function automatic int unsigned fill_level();
    return (wr_ptr - rd_ptr) & PTR_WRAP;
  endfunction

  // record length from its header, most significant byte first
  function automatic int unsigned record_len(int unsigned ptr, int unsigned hdr);
    int unsigned v = 0;
    for (int i = 0; i < hdr; i++) v = (v << 8) | mem_get(ptr + i);
    return v;
  endfunction

  // clamp, make room by dropping old data, lay down the header
  function automatic void open_write(int unsigned req);
    int unsigned cap  = ring_cap();
    int unsigned hdr  = hdr_count();
    int unsigned lim  = cap - hdr;
    int unsigned len  = req;
    int unsigned base = wr_ptr;
    int unsigned total, over, avail, stride;
    if (hdr == 1 && lim > 255) lim = 255;
    if (len > lim) len = lim;
    total = fill_level() + hdr + len;
    over = (total > cap) ? total - cap : 0;
    if (hdr == 0) begin
      rd_ptr = (rd_ptr + over) & PTR_WRAP;
    end else begin
      // whole records go, never past the old write position
      while (over > 0) begin
        avail = (base - rd_ptr) & PTR_WRAP;
        if (avail == 0) break;
        stride = hdr + record_len(rd_ptr, hdr);
        if (stride > avail) stride = avail;
        rd_ptr = (rd_ptr + stride) & PTR_WRAP;
        over -= (stride < over) ? stride : over;
      end
      if (over > 0) rd_ptr = base;
      for (int i = 0; i < hdr; i++) mem_put(base + i, 8'(len >> (8 * (hdr - 1 - i))));
    end
    wr_ptr  = (base + hdr + len) & PTR_WRAP;
    wr_left = len;
    wr_len  = len;
  endfunction

  // advance the mirror by one item; results land in ring_step_out
  function automatic bit apply_to_ring(ring_item_t it);
    int unsigned hdr, used, want, n, from, adv, dl, body;
    result_t r;
    ring_step_out.delete();
    if (it.func == FUNC_WRITE) begin
      if (it.first) open_write(it.length);
      else if (wr_left == 0) return 1'b0;
      if (wr_left > 0) begin
        mem_put(wr_ptr - wr_left, it.data);
        wr_left--;
      end
      if (wr_left == 0) begin
        r = '{element: 8'h00, has_element: 1'b0, count: 16'(wr_len), last: 1'b1};
        ring_step_out.push_back(r);
      end
      return 1'b1;
    end
    if (it.func != FUNC_POP && it.func != FUNC_PEEK) return 1'b0;
    hdr  = hdr_count();
    used = fill_level();
    want = (it.length > READ_CAP) ? READ_CAP : it.length;
    if (hdr == 0) begin
      n    = (want < used) ? want : used;
      from = rd_ptr;
      adv  = n;
    end else if (used == 0) begin
      n    = 0;
      from = rd_ptr;
      adv  = 0;
    end else begin
      dl   = record_len(rd_ptr, hdr);
      body = (used > hdr) ? used - hdr : 0;
      n    = (want < dl) ? want : dl;
      if (n > body) n = body;
      from = rd_ptr + hdr;
      adv  = dl + hdr;
      if (adv > used) adv = used;
    end
    if (it.func == FUNC_POP) rd_ptr = (rd_ptr + adv) & PTR_WRAP;
    if (n == 0) begin
      ring_step_out.push_back(RUN_EMPTY);
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        r = '{element: mem_get(from + k), has_element: 1'b1,
              count: (k + 1 == n) ? 16'(n) : 16'd0, last: (k + 1 == n)};
        ring_step_out.push_back(r);
      end
    end
    return 1'b1;
  endfunction

  function automatic ring_item_t make_item(logic [FUNC_BITS-1:0] f, logic fst,
                                           logic [LEN_BITS-1:0] len,
                                           logic [DATA_BITS-1:0] d);
    ring_item_t it;
    it.func   = f;
    it.first  = fst;
    it.length = len;
    it.data   = d;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[cycle %0d] mismatch on %s: got 0x%0h, want 0x%0h",
             cycle_count, what, got, want);
    mismatches++;
  endtask

  // present one item in bursts with random gaps, then update the mirror
  task automatic send_item(input ring_item_t it, input check_e chk, input result_t typed);
    int unsigned gap;
    bit taken;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    start  <= 1'b1;
    func   <= it.func;
    first  <= it.first;
    length <= it.length;
    data   <= it.data;
    do @(posedge clk); while (busy);
    taken = apply_to_ring(it);
    if (taken) items_done++;
    if (chk == CHK_MODEL) begin
      foreach (ring_step_out[k]) awaited_q.push_back(ring_step_out[k]);
    end else if (chk == CHK_ONE) begin
      awaited_q.push_back(typed);
    end
  endtask

  // follow-on elements of a write, random payload
  task automatic send_elements(input int unsigned n);
    repeat (n) begin
      send_item(make_item(FUNC_WRITE, 1'b0, 16'($urandom), 8'($urandom)),
                CHK_MODEL, RUN_EMPTY);
    end
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    start <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CAPACITY_LOG2) begin
      cap_log2_reg = val;
      clear_ring();
    end else if (idx == REG_HEADER_ELEMENTS) begin
      hdr_reg = val[HDR_BITS-1:0];
      clear_ring();
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    result_t due;
    if (!rst && result_strobe === 1'b1) begin
      if (awaited_q.size() == 0) begin
        report_mismatch("unexpected result element", element, 0);
      end else begin
        due = awaited_q.pop_front();
        if (element !== due.element) report_mismatch("element", element, due.element);
        if (has_element !== due.has_element)
          report_mismatch("has_element", has_element, due.has_element);
        if (count !== due.count) report_mismatch("count", count, due.count);
        if (last !== due.last) report_mismatch("last", last, due.last);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t        plan [$];
    int          goal, phase_goal;
    int unsigned pick, len, n;
    logic [CFG_DATA_BITS-1:0] cap_val, hdr_val;

    clear_ring();
    foreach (ring_mem[i]) ring_mem[i] = '0;

    // directed commands
    plan = '{
      // empty pop straight after reset
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b0, 16'hFFFF, 8'h00}, CHK_ONE, RUN_EMPTY},
      // fill the low part of the store, the only part later phases reach
      '{ROW_CFG, REG_CAPACITY_LOG2, FILL_CAP_LOG2, NO_ITEM, CHK_NONE, RUN_EMPTY},
      '{ROW_FILL, 2'd0, 4'd0, NO_ITEM, CHK_MODEL, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_PEEK, 1'b1, 16'h0000, 8'h00}, CHK_ONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b0, 16'hFFFF, 8'hFF}, CHK_MODEL, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_PEEK, 1'b0, 16'h0001, 8'h00}, CHK_MODEL, RUN_EMPTY},
      // unknown command and stray element are dropped silently
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_NONE, 1'b1, 16'hFFFF, 8'hFF}, CHK_NONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b0, 16'h0000, 8'h00}, CHK_NONE, RUN_EMPTY},
      // capacity code zero behaves as two elements
      '{ROW_CFG, REG_CAPACITY_LOG2, 4'd0, NO_ITEM, CHK_NONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b1, 16'h0000, 8'h00}, CHK_ONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b1, 16'h0005, 8'hFF}, CHK_MODEL, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b0, 16'hFFFF, 8'h5A}, CHK_ONE, WROTE_2},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b1, 16'h0001, 8'h00}, CHK_MODEL, RUN_EMPTY},
      // one header element, record clamped to one element
      '{ROW_CFG, REG_HEADER_ELEMENTS, 4'd1, NO_ITEM, CHK_NONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b1, 16'hFFFF, 8'hA5}, CHK_ONE, WROTE_1},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_PEEK, 1'b0, 16'h0040, 8'h00}, CHK_MODEL, RUN_EMPTY},
      // zero-length pop still drops the record
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b0, 16'h0000, 8'h00}, CHK_ONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b0, 16'h0001, 8'h00}, CHK_ONE, RUN_EMPTY},
      // oversized capacity code and header code three
      '{ROW_CFG, REG_CAPACITY_LOG2, 4'd15, NO_ITEM, CHK_NONE, RUN_EMPTY},
      '{ROW_CFG, REG_HEADER_ELEMENTS, 4'hF, NO_ITEM, CHK_NONE, RUN_EMPTY},
      // two-byte header, abandoned write, then a short record
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b1, 16'd300, 8'h01}, CHK_MODEL, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b1, 16'd2, 8'h80}, CHK_MODEL, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_WRITE, 1'b0, 16'h0000, 8'h7F}, CHK_ONE, WROTE_2},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b0, 16'hFFFF, 8'h00}, CHK_MODEL, RUN_EMPTY},
      // write to an unused register index leaves the ring alone
      '{ROW_CFG, 2'd3, 4'hA, NO_ITEM, CHK_NONE, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_POP, 1'b0, 16'h0003, 8'h00}, CHK_MODEL, RUN_EMPTY},
      '{ROW_ITEM, 2'd0, 4'd0, '{FUNC_PEEK, 1'b0, 16'h0005, 8'h00}, CHK_ONE, RUN_EMPTY}
    };

    // reset
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: write_reg(plan[i].reg_idx, plan[i].reg_val);
        ROW_FILL: begin
          send_item(make_item(FUNC_WRITE, 1'b1, 16'hFFFF, 8'($urandom)), CHK_MODEL,
                    RUN_EMPTY);
          send_elements(wr_left);
        end
        default: send_item(plan[i].it, plan[i].chk, plan[i].res);
      endcase
    end

    // random phases, each under a fresh setting within the filled capacity
    goal = items_done + RANDOM_ITEMS;
    while (items_done < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) cap_val = 4'($urandom_range(1, 5));
      else if (pick < 9) cap_val = 4'($urandom_range(6, int'(FILL_CAP_LOG2)));
      else cap_val = 4'd0;
      hdr_val = 4'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_CAPACITY_LOG2, cap_val);
        write_reg(REG_HEADER_ELEMENTS, hdr_val);
      end else begin
        write_reg(REG_HEADER_ELEMENTS, hdr_val);
        write_reg(REG_CAPACITY_LOG2, cap_val);
      end
      if ($urandom_range(0, 5) == 0) write_reg(2'($urandom_range(2, 3)), 4'($urandom));

      phase_goal = items_done + $urandom_range(30, 60);
      while (items_done < phase_goal && items_done < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // write sequence, mostly short and complete
          pick = $urandom_range(0, 9);
          if (pick < 6) len = $urandom_range(0, (ring_cap() + 2 < 24) ? ring_cap() + 2 : 24);
          else if (pick < 8) len = $urandom_range(0, ring_cap() + 2);
          else len = 16'($urandom);
          send_item(make_item(FUNC_WRITE, 1'b1, 16'(len), 8'($urandom)), CHK_MODEL,
                    RUN_EMPTY);
          n = wr_left;
          if ((n > 40 && $urandom_range(0, 15) != 0) || $urandom_range(0, 7) == 0)
            n = $urandom_range(0, (n < 8) ? n : 8);
          send_elements(n);
        end else if (pick < 85) begin
          // pop or peek
          pick = $urandom_range(0, 9);
          if (pick < 6) len = $urandom_range(0, 70);
          else if (pick < 8) len = $urandom_range(0, 3);
          else len = 16'($urandom);
          send_item(make_item(($urandom_range(0, 1) == 1) ? FUNC_POP : FUNC_PEEK,
                              1'($urandom), 16'(len), 8'($urandom)), CHK_MODEL, RUN_EMPTY);
        end else if (pick < 92) begin
          // unknown command
          send_item(make_item(FUNC_NONE, 1'($urandom), 16'($urandom), 8'($urandom)),
                    CHK_MODEL, RUN_EMPTY);
        end else if (pick < 96) begin
          // element outside a write, or a late piece of an abandoned one
          send_item(make_item(FUNC_WRITE, 1'b0, 16'($urandom), 8'($urandom)),
                    CHK_MODEL, RUN_EMPTY);
        end else begin
          // fully random item
          send_item(make_item(2'($urandom), 1'($urandom), 16'($urandom), 8'($urandom)),
                    CHK_MODEL, RUN_EMPTY);
        end
      end
    end

    // drain and finish
    start <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_q.size() != 0) report_mismatch("results never seen", awaited_q.size(), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
